[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

[design/ipu_pkg.sv]
// ---------------------------------------------------------------------------
// Integer pixel upscaler package
// Types and fixed constants shared by the upscaler modules.
// ---------------------------------------------------------------------------
package ipu_pkg;

  localparam int SCALE_W = 5;
  localparam int WIDTH_W = 12;
  localparam int OWED_W  = 4;
  localparam int PIX_W   = 24;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic REG_SCALE     = 1'b0;
  localparam logic REG_ROW_WIDTH = 1'b1;

  localparam logic REQ_PIXEL  = 1'b0;
  localparam logic REQ_REPLAY = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t             pix;
    logic [SCALE_W-1:0] cnt;
    logic               ends;
    logic [1:0]         pad;
    logic               err;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[design/ipu_front.sv]
// ---------------------------------------------------------------------------
// Upscaler front end
// Accepts items, classifies them, keeps the row state and the line store, and
// hands one command per item to the queue.
// ---------------------------------------------------------------------------
module ipu_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SCALE = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ipu_pkg::SCALE_W-1:0]  scale,
  input  logic [ipu_pkg::WIDTH_W-1:0]  row_width,
  input  logic                         push,
  input  logic                         req_type,
  input  logic [7:0]                   blue,
  input  logic [7:0]                   green,
  input  logic [7:0]                   red,
  output logic                         full,
  input  ipu_pkg::qstat_t              qstat,
  output logic                         q_push,
  output ipu_pkg::cmd_t                q_data
);
  import ipu_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  pixel_t             line_store [MAX_WIDTH];
  pixel_t             rd_data;
  logic [COL_W-1:0]   write_column;
  logic [COL_W-1:0]   replay_column;
  logic [OWED_W-1:0]  rows_owed;
  logic               s1_valid;
  logic               s1_replay;
  cmd_t               s1_cmd;

  logic [SCALE_W-1:0] n_eff;
  logic [WIDTH_W-1:0] w_eff;
  logic [1:0]         pad_mod;
  logic [1:0]         pad;
  logic [COL_W-1:0]   col_sel;
  logic               ends;
  logic               is_err;
  logic               accept;
  logic               do_write;
  logic               do_read;
  pixel_t             in_pix;

  always_comb begin
    if (scale == '0) begin
      n_eff = SCALE_W'(1);
    end else if (32'(scale) > 32'(MAX_SCALE)) begin
      n_eff = SCALE_W'(MAX_SCALE);
    end else begin
      n_eff = scale;
    end
    if (row_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = row_width;
    end
  end

  assign pad_mod  = 2'(w_eff[1:0] * n_eff[1:0] * 2'd3);
  assign pad      = 2'd0 - pad_mod;
  assign col_sel  = (req_type == REQ_PIXEL) ? write_column : replay_column;
  assign ends     = (32'(col_sel) + 32'd1) >= 32'(w_eff);
  assign is_err   = (req_type == REQ_PIXEL) ? (rows_owed != '0) : (rows_owed == '0);
  assign full     = s1_valid && qstat.full;
  assign accept   = push && !full;
  assign do_write = accept && !is_err && (req_type == REQ_PIXEL);
  assign do_read  = accept && !is_err && (req_type == REQ_REPLAY);
  assign in_pix   = {red, green, blue};

  always_ff @(posedge clk) begin
    if (do_write) begin
      line_store[write_column] <= in_pix;
    end
    if (do_read) begin
      rd_data <= line_store[replay_column];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_column  <= '0;
      replay_column <= '0;
      rows_owed     <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (!full) begin
        s1_valid <= accept;
      end
      if (do_write) begin
        if (ends) begin
          write_column  <= '0;
          replay_column <= '0;
          rows_owed     <= OWED_W'(n_eff - SCALE_W'(1));
        end else begin
          write_column <= write_column + COL_W'(1);
        end
      end
      if (do_read) begin
        if (ends) begin
          replay_column <= '0;
          rows_owed     <= rows_owed - OWED_W'(1);
        end else begin
          replay_column <= replay_column + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_replay <= do_read;
      if (is_err) begin
        s1_cmd.pix  <= '0;
        s1_cmd.cnt  <= SCALE_W'(1);
        s1_cmd.ends <= 1'b0;
        s1_cmd.pad  <= 2'd0;
        s1_cmd.err  <= 1'b1;
      end else begin
        s1_cmd.pix  <= in_pix;
        s1_cmd.cnt  <= n_eff;
        s1_cmd.ends <= ends;
        s1_cmd.pad  <= ends ? pad : 2'd0;
        s1_cmd.err  <= 1'b0;
      end
    end
  end

  assign q_push = s1_valid && !qstat.full;

  always_comb begin
    q_data = s1_cmd;
    if (s1_replay) begin
      q_data.pix = rd_data;
    end
  end

endmodule

[design/ipu_queue.sv]
// ---------------------------------------------------------------------------
// Upscaler command queue
// Short first-in first-out store between the front end and the back end.
// ---------------------------------------------------------------------------
module ipu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  ipu_pkg::cmd_t   wr_data,
  input  logic            rd,
  output ipu_pkg::cmd_t   rd_data,
  output ipu_pkg::qstat_t qstat
);
  import ipu_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign do_wr       = wr && !qstat.full;
  assign do_rd       = rd && !qstat.empty;
  assign rd_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

[design/ipu_back.sv]
// ---------------------------------------------------------------------------
// Upscaler back end
// Expands each queued command into its copies, one result beat per cycle while
// the output is popped or empty, through an output register.
// ---------------------------------------------------------------------------
module ipu_back (
  input  logic            clk,
  input  logic            rst,
  input  ipu_pkg::qstat_t qstat,
  input  ipu_pkg::cmd_t   q_data,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_green,
  output logic [7:0]      out_red,
  output logic            last_of_run,
  output logic            row_end,
  output logic [1:0]      pad_bytes,
  output logic            error
);
  import ipu_pkg::*;

  logic               out_valid;
  logic [SCALE_W-1:0] copy;
  logic               advance;
  logic               last_copy;

  assign empty     = !out_valid;
  assign advance   = !out_valid || pop;
  assign last_copy = (copy == q_data.cnt - SCALE_W'(1));
  assign q_pop     = advance && !qstat.empty && last_copy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      copy      <= '0;
    end else if (advance) begin
      out_valid <= !qstat.empty;
      if (!qstat.empty) begin
        copy <= last_copy ? '0 : copy + SCALE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !qstat.empty) begin
      out_blue    <= q_data.pix[7:0];
      out_green   <= q_data.pix[15:8];
      out_red     <= q_data.pix[23:16];
      last_of_run <= last_copy;
      row_end     <= last_copy && q_data.ends;
      pad_bytes   <= last_copy ? q_data.pad : 2'd0;
      error       <= q_data.err;
    end
  end

endmodule

[design/integer_pixel_upscaler_core.sv]
// Path: an item's first result beat passes the front-end stage register, the command
// queue and the output register. Throughput: one result beat per cycle from the back
// end while beats are popped; an item gives scale-factor beats (one for an error), and
// the front end takes one item a cycle while the four-entry command queue has room.
// Reset clears the row state, the queue and the output register, and sets scale and
// row width to one; the line store is not cleared and holds nothing until written.
// ---------------------------------------------------------------------------
// Integer pixel upscaler core
// Nearest-neighbour upscaler with a line store, a command queue and a copy
// generator, configured over an APB-style port.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_pixel_upscaler_core #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SCALE = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipu_pkg::ADDR_W-1:0]  paddr,
  input  logic [ipu_pkg::DATA_W-1:0]  pwdata,
  output logic [ipu_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  logic                        req_type,
  input  logic [7:0]                  blue,
  input  logic [7:0]                  green,
  input  logic [7:0]                  red,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_red,
  output logic                        last_of_run,
  output logic                        row_end,
  output logic [1:0]                  pad_bytes,
  output logic                        error
);
  import ipu_pkg::*;

  logic [SCALE_W-1:0] scale;
  logic [WIDTH_W-1:0] row_width;
  logic               cfg_wr;
  logic               q_push;
  logic               q_pop;
  cmd_t               q_wr_data;
  cmd_t               q_rd_data;
  qstat_t             qstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_W'(1);
      row_width <= WIDTH_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SCALE:     scale     <= pwdata[SCALE_W-1:0];
        REG_ROW_WIDTH: row_width <= pwdata[WIDTH_W-1:0];
        default:       scale     <= scale;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCALE:     prdata = DATA_W'(scale);
      REG_ROW_WIDTH: prdata = DATA_W'(row_width);
      default:       prdata = '0;
    endcase
  end

  ipu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .scale     (scale),
    .row_width (row_width),
    .push      (push),
    .req_type  (req_type),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .full      (full),
    .qstat     (qstat),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  ipu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .qstat   (qstat)
  );

  ipu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_blue    (out_blue),
    .out_green   (out_green),
    .out_red     (out_red),
    .last_of_run (last_of_run),
    .row_end     (row_end),
    .pad_bytes   (pad_bytes),
    .error       (error)
  );

  `ASSERT_IMPLY(a_error_beat, clk, rst, !empty && error, last_of_run && !row_end && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && pad_bytes == 2'd0, "error beat carries data")
  `ASSERT_IMPLY(a_row_end_last, clk, rst, !empty && row_end, last_of_run, "row end on a beat that is not the last copy")
  `ASSERT_IMPLY(a_pad_at_row_end, clk, rst, !empty && !row_end, pad_bytes == 2'd0, "padding away from a row end")
  `ASSERT_NEVER(a_pop_empty_queue, clk, rst, q_pop && qstat.empty, "command taken from an empty queue")

endmodule
